>>> rtl/core/pip_pkg.sv
// Shared constants and types for the point-in-polygon test block.
package pip_pkg;

  // Table and number formats.
  localparam int MAX_VERTICES      = 16;
  localparam int COORD_BITS        = 16;
  localparam int FRACTION_BITS     = 8;
  localparam int POINT_BITS        = COORD_BITS + FRACTION_BITS;
  localparam int COUNT_W           = 5;
  localparam int VIDX_W            = 4;
  localparam int MIN_POLY_VERTICES = 3;

  // Widths of the exact crossing test.
  localparam int DIFF_W  = POINT_BITS + 1;
  localparam int DELTA_W = COORD_BITS + 1;
  localparam int PROD_W  = DIFF_W + DELTA_W;

  // Request operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Query token handed from cell to cell.
  typedef struct packed {
    logic signed [POINT_BITS-1:0] px;
    logic signed [POINT_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] prev_x;
    logic signed [COORD_BITS-1:0] prev_y;
    logic                         parity;
    logic                         pend;
    logic signed [PROD_W-1:0]     p1;
    logic signed [PROD_W-1:0]     p2;
  } token_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic                         advance;
    logic [COUNT_W-1:0]           count;
    logic                         poly_ok;
    logic                         wr_en;
    logic [VIDX_W-1:0]            wr_index;
    logic signed [COORD_BITS-1:0] wr_x;
    logic signed [COORD_BITS-1:0] wr_y;
  } cell_ctl_t;

endpackage

>>> rtl/core/pip_in_if.sv
// Request channel: vertex writes and point queries.
interface pip_in_if
  import pip_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [VIDX_W-1:0]            vertex_index;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [POINT_BITS-1:0] point_x;
  logic signed [POINT_BITS-1:0] point_y;

  modport source (output valid, operation, vertex_index, vertex_x, vertex_y,
                  point_x, point_y, input ready);
  modport sink (input valid, operation, vertex_index, vertex_x, vertex_y,
                point_x, point_y, output ready);
endinterface

>>> rtl/core/pip_out_if.sv
// Result channel: one inside/outside answer per query.
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

>>> rtl/core/pip_cfg_if.sv
// Configuration write channel carrying the vertex count.
interface pip_cfg_if
  import pip_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

>>> rtl/core/pip_cell.sv
// One cell of the edge chain: holds one vertex and tests the edge that ends at it.
module pip_cell
  import pip_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cell_ctl_t                    ctl,
  input  logic                         tok_valid_in,
  input  token_t                       tok_in,
  output logic                         tok_valid_out,
  output token_t                       tok_out,
  output logic signed [COORD_BITS-1:0] vx,
  output logic signed [COORD_BITS-1:0] vy
);

  logic                         active;
  logic                         less_in;
  logic signed [POINT_BITS-1:0] sxi;
  logic signed [POINT_BITS-1:0] syi;
  logic signed [POINT_BITS-1:0] syj;
  logic signed [DIFF_W-1:0]     diff_x;
  logic signed [DIFF_W-1:0]     diff_y;
  logic signed [DELTA_W-1:0]    dy;
  logic signed [DELTA_W-1:0]    dx;
  logic signed [DELTA_W-1:0]    dy_abs;
  logic signed [DELTA_W-1:0]    dx_adj;
  logic                         straddle;
  token_t                       tok_next;

  // Stored vertex, written by a vertex request that names this slot.
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_index == VIDX_W'(INDEX))) begin
      vx <= ctl.wr_x;
      vy <= ctl.wr_y;
    end
  end

  // The cell takes part only when its slot is in use and the polygon is valid.
  assign active = ctl.poly_ok && (COUNT_W'(INDEX) < ctl.count);

  // Finish the comparison left pending by the previous cell.
  assign less_in = tok_in.p1 < tok_in.p2;

  // Edge from the previous vertex to this one, in scaled units.
  always_comb begin
    sxi      = POINT_BITS'(vx) <<< FRACTION_BITS;
    syi      = POINT_BITS'(vy) <<< FRACTION_BITS;
    syj      = POINT_BITS'(tok_in.prev_y) <<< FRACTION_BITS;
    diff_x   = DIFF_W'(tok_in.px) - DIFF_W'(sxi);
    diff_y   = DIFF_W'(tok_in.py) - DIFF_W'(syi);
    dy       = DELTA_W'(tok_in.prev_y) - DELTA_W'(vy);
    dx       = DELTA_W'(tok_in.prev_x) - DELTA_W'(vx);
    dy_abs   = dy[DELTA_W-1] ? -dy : dy;
    dx_adj   = dy[DELTA_W-1] ? -dx : dx;
    straddle = (syi > tok_in.py) != (syj > tok_in.py);

    tok_next        = tok_in;
    tok_next.parity = tok_in.parity ^ (tok_in.pend && less_in);
    tok_next.prev_x = vx;
    tok_next.prev_y = vy;
    tok_next.pend   = active && (vy != tok_in.prev_y) && straddle;
    tok_next.p1     = PROD_W'(diff_x) * PROD_W'(dy_abs);
    tok_next.p2     = PROD_W'(dx_adj) * PROD_W'(diff_y);
  end

  // Token register towards the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid_out <= 1'b0;
    end else if (ctl.advance) begin
      tok_valid_out <= tok_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> rtl/core/point_in_polygon_test_top.sv
// Top level of the point-in-polygon test: request decode, cell chain and result register.
//
// Usage. The query channel carries two kinds of request. A vertex write
// (operation 0) stores one integer vertex into table slot vertex_index and
// gives no result. A point query (operation 1) brings a fixed-point point with
// 8 fraction bits and gives exactly one inside_res on the result channel, 1
// when the point lies inside the polygon by the even-odd rule. The cfg channel
// writes vertex_count; the user writes it only while the block is idle, which
// the block itself does not enforce; it is always ready. Counts above 16 act
// as 16, and fewer than three vertices always answer outside.
// Timing. A query walks a chain of 16 cells, one edge test per cell per cycle
// unless the chain stalls, and its result is then registered. The query
// channel is held off while a query is in the chain and is ready again as the
// result is registered, so one query at a time is in the chain; vertex writes
// are taken one per cycle when idle. A finished result waits in the output
// register while further requests are taken; if it is still waiting when the
// next query reaches the end of the chain, the chain holds until it is taken.
// Reset clears the count, the chain and the output register; table contents
// are undefined until written.
module point_in_polygon_test_top
  import pip_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pip_in_if.sink      query,
  pip_out_if.source   result,
  pip_cfg_if.sink     cfg
);

  localparam int LAST = MAX_VERTICES - 1;

  logic [COUNT_W-1:0]           vertex_count;
  logic [COUNT_W-1:0]           count_sat;
  logic [VIDX_W-1:0]            last_idx;
  logic                         busy;
  logic                         req_acc;
  logic                         query_acc;
  logic                         stall;
  logic                         tail_inside;
  logic                         out_valid;
  logic                         out_inside;
  cell_ctl_t                    ctl;
  token_t                       inject_tok;
  token_t                       chain_tok [MAX_VERTICES+1];
  logic                         chain_vld [MAX_VERTICES+1];
  logic [MAX_VERTICES-1:0]      cells_vld;
  logic signed [COORD_BITS-1:0] cell_vx [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] cell_vy [MAX_VERTICES];

  // Configuration register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      vertex_count <= cfg.vertex_count;
    end
  end

  assign count_sat = (vertex_count > COUNT_W'(MAX_VERTICES)) ?
                     COUNT_W'(MAX_VERTICES) : vertex_count;
  assign last_idx  = VIDX_W'(count_sat - COUNT_W'(1));

  // Request acceptance: one query in the chain at a time.
  assign query.ready = !busy;
  assign req_acc     = query.valid && query.ready;
  assign query_acc   = req_acc && (query.operation == OP_QUERY);

  // The chain holds when its last token cannot move into the result register.
  assign stall = chain_vld[MAX_VERTICES] && out_valid && !result.ready;

  always_comb begin
    ctl          = '0;
    ctl.advance  = !stall;
    ctl.count    = count_sat;
    ctl.poly_ok  = count_sat >= COUNT_W'(MIN_POLY_VERTICES);
    ctl.wr_en    = req_acc && (query.operation == OP_WRITE);
    ctl.wr_index = query.vertex_index;
    ctl.wr_x     = query.vertex_x;
    ctl.wr_y     = query.vertex_y;
  end

  // The first edge runs from the last vertex in use to vertex 0.
  always_comb begin
    inject_tok        = '0;
    inject_tok.px     = query.point_x;
    inject_tok.py     = query.point_y;
    inject_tok.prev_x = cell_vx[last_idx];
    inject_tok.prev_y = cell_vy[last_idx];
  end

  assign chain_tok[0] = inject_tok;
  assign chain_vld[0] = query_acc;

  // Row of edge cells.
  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    pip_cell #(
      .INDEX (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .tok_valid_in  (chain_vld[g]),
      .tok_in        (chain_tok[g]),
      .tok_valid_out (chain_vld[g+1]),
      .tok_out       (chain_tok[g+1]),
      .vx            (cell_vx[g]),
      .vy            (cell_vy[g])
    );
    assign cells_vld[g] = chain_vld[g+1];
  end

  // Busy from acceptance until the token leaves the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (query_acc) begin
      busy <= 1'b1;
    end else if (chain_vld[MAX_VERTICES] && !stall) begin
      busy <= 1'b0;
    end
  end

  // Resolve the last pending comparison and register the answer.
  assign tail_inside = chain_tok[MAX_VERTICES].parity ^
                       (chain_tok[MAX_VERTICES].pend &&
                        (chain_tok[MAX_VERTICES].p1 < chain_tok[MAX_VERTICES].p2));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chain_vld[MAX_VERTICES] && !stall) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_vld[MAX_VERTICES] && !stall) begin
      out_inside <= tail_inside;
    end
  end

  assign result.valid      = out_valid;
  assign result.inside_res = out_inside;

  // At most one query travels the chain.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cells_vld))
    else $error("more than one query token in the cell chain");

  // No request is taken while a query is in the chain.
  a_hold_off: assert property (@(posedge clk) disable iff (rst)
    (cells_vld != '0) |-> !query.ready)
    else $error("request channel ready while a query is in flight");

  // An accepted query enters the first cell.
  a_inject: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> (chain_vld[1] && busy))
    else $error("accepted query did not enter the chain");

  // A stalled result keeps the last token in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready && chain_vld[MAX_VERTICES]) |=>
      (chain_vld[MAX_VERTICES] && $stable(chain_tok[LAST+1])))
    else $error("chain moved while the result register was full");

endmodule

>>> sim/tb.sv
// Testbench for the point-in-polygon test block: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module tb;
  import pip_pkg::*;

  // One request as the driver presents it.
  typedef struct packed {
    logic                         op;
    logic [VIDX_W-1:0]            idx;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [POINT_BITS-1:0] px;
    logic signed [POINT_BITS-1:0] py;
  } request_t;

  localparam int RANDOM_REQUESTS = 1850;
  localparam int SETTLE_CYCLES   = 20;
  localparam int HOLD_CYCLES     = 300;
  localparam int POINT_MIN       = -(1 << (POINT_BITS - 1));
  localparam int POINT_MAX       = (1 << (POINT_BITS - 1)) - 1;
  localparam int COORD_MIN       = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX       = (1 << (COORD_BITS - 1)) - 1;

  logic clk;
  logic rst;

  pip_in_if  query_ch ();
  pip_out_if result_ch ();
  pip_cfg_if cfg_ch ();

  point_in_polygon_test_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Predictor state: the polygon table and vertex count as the block should hold them.
  logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  logic [COUNT_W-1:0]           poly_count;
  bit                           inside_q [$];
  bit                           want_inside;
  int                           errors;

  // Stimulus bookkeeping: pending requests and the polygon the generator has loaded.
  request_t pending_q [$];
  request_t cur_req;
  int       requests_queued;
  int       requests_taken;
  int       gen_x [MAX_VERTICES];
  int       gen_y [MAX_VERTICES];
  bit [MAX_VERTICES-1:0] loaded;

  logic req_taken;
  logic cfg_taken;
  int   burst_left;
  int   gap_left;

  bit   want_hold;
  bit   hold_used;
  int   hold_left;
  int   stall_mode;
  int   mode_left;
  int   tick;
  bit   rx_open;

  // Clock and known values on every input from time zero.
  initial begin
    clk = 1'b0;
    query_ch.valid = 1'b0;
    query_ch.operation = OP_WRITE;
    query_ch.vertex_index = '0;
    query_ch.vertex_x = '0;
    query_ch.vertex_y = '0;
    query_ch.point_x = '0;
    query_ch.point_y = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.vertex_count = '0;
    forever #10 clk = ~clk;
  end

  // Even-odd ray cast over the stored polygon, with the crossing test done exactly.
  function automatic bit point_inside(logic signed [POINT_BITS-1:0] px,
                                      logic signed [POINT_BITS-1:0] py);
    int     n;
    int     i;
    int     j;
    bit     par;
    longint scale;
    longint lpx;
    longint lpy;
    longint xi;
    longint yi;
    longint xj;
    longint yj;
    longint syi;
    longint syj;
    longint dx;
    longint dy;
    scale = longint'(1) << FRACTION_BITS;
    lpx = longint'(px);
    lpy = longint'(py);
    n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    par = 1'b0;
    if (n >= MIN_POLY_VERTICES) begin
      j = n - 1;
      for (i = 0; i < n; i++) begin
        xi = longint'(poly_x[i]);
        yi = longint'(poly_y[i]);
        xj = longint'(poly_x[j]);
        yj = longint'(poly_y[j]);
        syi = yi * scale;
        syj = yj * scale;
        // Horizontal edges never cross; otherwise the edge must straddle the point's y.
        if (yi != yj && ((syi > lpy) != (syj > lpy))) begin
          dy = yj - yi;
          dx = xj - xi;
          if (dy < 0) begin
            dy = -dy;
            dx = -dx;
          end
          if ((lpx - xi * scale) * dy < dx * (lpy - syi)) par = ~par;
        end
        j = i;
      end
    end
    return par;
  endfunction

  // Monitor: applies accepted requests to the predictor and checks each answer.
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      req_taken <= query_ch.valid && query_ch.ready;
      cfg_taken <= cfg_ch.valid && cfg_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) poly_count = cfg_ch.vertex_count;
      if (query_ch.valid && query_ch.ready) begin
        requests_taken++;
        if (query_ch.operation == OP_WRITE) begin
          poly_x[query_ch.vertex_index] = query_ch.vertex_x;
          poly_y[query_ch.vertex_index] = query_ch.vertex_y;
        end else begin
          inside_q.push_back(point_inside(query_ch.point_x, query_ch.point_y));
        end
      end
      if (result_ch.valid && result_ch.ready) begin
        if (inside_q.size() == 0) begin
          $display("%0t: unrequested answer, expected none, got inside_res=%0b",
                   $time, result_ch.inside_res);
          errors++;
        end else begin
          want_inside = inside_q.pop_front();
          if (result_ch.inside_res !== want_inside) begin
            $display("%0t: inside_res mismatch, expected %0b, got %0b",
                     $time, want_inside, result_ch.inside_res);
            errors++;
          end
        end
      end
    end
  end

  // Driver: presents pending requests in bursts separated by random gaps.
  always @(negedge clk) begin
    if (!query_ch.valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        query_ch.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_req = pending_q.pop_front();
        query_ch.valid <= 1'b1;
        query_ch.operation <= cur_req.op;
        query_ch.vertex_index <= cur_req.idx;
        query_ch.vertex_x <= cur_req.vx;
        query_ch.vertex_y <= cur_req.vy;
        query_ch.point_x <= cur_req.px;
        query_ch.point_y <= cur_req.py;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        query_ch.valid <= 1'b0;
      end
    end
  end

  // Long hold-off of the result side, counted here once it has been asked for.
  always @(negedge clk) begin
    if (want_hold && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: switches between stall patterns of random length.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 200);
      stall_mode = $urandom_range(0, 3);
    end else begin
      mode_left--;
    end
    tick++;
    case (stall_mode)
      0: rx_open = 1'b1;
      1: rx_open = 1'($urandom_range(0, 1));
      2: rx_open = (tick % 5 == 0);
      default: rx_open = ($urandom_range(0, 7) != 0);
    endcase
    result_ch.ready <= (hold_left == 0) && rx_open;
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic push_write(int slot, int x, int y);
    request_t r;
    r.op = OP_WRITE;
    r.idx = VIDX_W'(slot);
    r.vx = COORD_BITS'(x);
    r.vy = COORD_BITS'(y);
    r.px = POINT_BITS'($urandom);
    r.py = POINT_BITS'($urandom);
    pending_q.push_back(r);
    requests_queued++;
    gen_x[slot] = x;
    gen_y[slot] = y;
    loaded[slot] = 1'b1;
  endtask

  task automatic push_query(int px, int py);
    request_t r;
    r.op = OP_QUERY;
    r.idx = VIDX_W'($urandom);
    r.vx = COORD_BITS'($urandom);
    r.vy = COORD_BITS'($urandom);
    r.px = POINT_BITS'(px);
    r.py = POINT_BITS'(py);
    pending_q.push_back(r);
    requests_queued++;
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, 32'hFFFF)) + COORD_MIN;
  endfunction

  function automatic int rand_point();
    return int'($urandom_range(0, 32'hFF_FFFF)) + POINT_MIN;
  endfunction

  // Writes slots 0 to n-1 with a random polygon of random extent.
  task automatic load_polygon(int n);
    int i;
    int r;
    int cx;
    int cy;
    int y;
    case ($urandom_range(0, 3))
      0: r = $urandom_range(1, 8);
      1: r = $urandom_range(10, 300);
      2: r = $urandom_range(1000, 20000);
      default: r = COORD_MAX;
    endcase
    cx = (r == COORD_MAX) ? 0 : rand_coord();
    cy = (r == COORD_MAX) ? 0 : rand_coord();
    for (i = 0; i < n; i++) begin
      // Reusing the previous y now and then gives horizontal edges.
      if (i > 0 && $urandom_range(0, 3) == 0) y = gen_y[i-1];
      else y = clamp(cy + int'($urandom_range(0, 2 * r)) - r, COORD_MIN, COORD_MAX);
      push_write(i, clamp(cx + int'($urandom_range(0, 2 * r)) - r, COORD_MIN, COORD_MAX), y);
    end
  endtask

  // A random query, or one aimed at the loaded polygon: its box, its vertices or its edge midpoints.
  task automatic push_aimed_query(int n);
    int i;
    int a;
    int b;
    int mode;
    int lo_x;
    int hi_x;
    int lo_y;
    int hi_y;
    int px;
    int py;
    mode = $urandom_range(0, 9);
    if (n < MIN_POLY_VERTICES || mode == 0) begin
      push_query(rand_point(), rand_point());
    end else begin
      lo_x = gen_x[0];
      hi_x = gen_x[0];
      lo_y = gen_y[0];
      hi_y = gen_y[0];
      for (i = 1; i < n; i++) begin
        if (gen_x[i] < lo_x) lo_x = gen_x[i];
        if (gen_x[i] > hi_x) hi_x = gen_x[i];
        if (gen_y[i] < lo_y) lo_y = gen_y[i];
        if (gen_y[i] > hi_y) hi_y = gen_y[i];
      end
      a = $urandom_range(0, n - 1);
      b = (a == 0) ? n - 1 : a - 1;
      px = (lo_x - 1 + int'($urandom_range(0, hi_x - lo_x + 2))) * (1 << FRACTION_BITS);
      py = (lo_y - 1 + int'($urandom_range(0, hi_y - lo_y + 2))) * (1 << FRACTION_BITS);
      if ($urandom_range(0, 9) > 2) px += $urandom_range(0, (1 << FRACTION_BITS) - 1);
      if ($urandom_range(0, 9) > 2) py += $urandom_range(0, (1 << FRACTION_BITS) - 1);
      case (mode)
        1: begin
          // Exactly on a vertex.
          px = gen_x[a] * (1 << FRACTION_BITS);
          py = gen_y[a] * (1 << FRACTION_BITS);
        end
        2: begin
          // Exactly on the midpoint of an edge, so on its crossing.
          px = (gen_x[a] + gen_x[b]) * (1 << (FRACTION_BITS - 1));
          py = (gen_y[a] + gen_y[b]) * (1 << (FRACTION_BITS - 1));
        end
        3: py = gen_y[a] * (1 << FRACTION_BITS);
        default: ;
      endcase
      push_query(clamp(px, POINT_MIN, POINT_MAX), clamp(py, POINT_MIN, POINT_MAX));
    end
  endtask

  // Waits until every request has been taken and answered, then lets the chain drain.
  task automatic wait_idle();
    while (requests_taken != requests_queued || inside_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the vertex count register; called only while the block is idle.
  task automatic set_count(int c);
    cfg_ch.vertex_count <= COUNT_W'(c);
    cfg_ch.valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_ch.valid <= 1'b0;
  endtask

  // One phase: set the count, load a polygon if needed, then a run of queries and stray writes.
  task automatic run_phase(int c, int nq, bit hold);
    int  n;
    int  i;
    bit  reuse;
    n = (c > MAX_VERTICES) ? MAX_VERTICES : c;
    set_count(c);
    reuse = ($urandom_range(0, 2) == 0);
    for (i = 0; i < n; i++) if (!loaded[i]) reuse = 1'b0;
    if (n >= MIN_POLY_VERTICES && !reuse) load_polygon(n);
    for (i = 0; i < nq; i++) begin
      if ($urandom_range(0, 19) == 0) push_write($urandom_range(0, MAX_VERTICES - 1),
                                                 rand_coord(), rand_coord());
      else push_aimed_query(n);
    end
    if (hold) want_hold <= 1'b1;
    wait_idle();
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    int first_counts [7];
    int directed_made;
    int phase;
    int c;
    first_counts = '{16, 17, 31, 3, 1, 2, 8};
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty polygon: every query is outside; then a triangle spanning the full range.
    set_count(0);
    push_query(POINT_MIN, POINT_MAX);
    push_query(POINT_MAX, POINT_MIN);
    push_query(0, 0);
    push_write(0, COORD_MIN, COORD_MIN);
    push_write(1, COORD_MAX, COORD_MIN);
    push_write(2, 0, COORD_MAX);
    wait_idle();
    set_count(3);
    push_query(0, 0);
    push_query(POINT_MIN, POINT_MIN);
    push_query(POINT_MAX, POINT_MAX);
    push_query(0, POINT_MIN);
    wait_idle();

    // Two vertices in use are too few for a polygon.
    set_count(2);
    push_query(0, 0);
    wait_idle();

    // A square of side ten: centre, both vertical edges, a corner, the top, just inside a corner and just outside.
    push_write(0, 0, 0);
    push_write(1, 10, 0);
    push_write(2, 10, 10);
    push_write(3, 0, 10);
    wait_idle();
    set_count(4);
    push_query(1280, 1280);
    push_query(0, 1280);
    push_query(2560, 1280);
    push_query(0, 0);
    push_query(1280, 2560);
    push_query(1, 1);
    push_query(-1, 1280);
    wait_idle();
    directed_made = requests_queued;

    // Random phases over many counts, the saturating ones among them.
    phase = 0;
    while (requests_queued < directed_made + RANDOM_REQUESTS) begin
      if (phase < 7) c = first_counts[phase];
      else if ($urandom_range(0, 9) < 7) c = $urandom_range(MIN_POLY_VERTICES, MAX_VERTICES);
      else c = $urandom_range(0, (1 << COUNT_W) - 1);
      run_phase(c, (phase == 3) ? 80 : $urandom_range(10, 60), phase == 3);
      phase++;
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
